// ===== rtl/tpi_pkg.sv =====
// Types and constants of the three-plane intersection block.
`timescale 1ns / 1ps
`default_nettype none
package tpi_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam logic REG_DET_EPSILON = 1'b0;
  localparam logic [15:0] DET_EPSILON_RST = 16'd1;

  typedef struct packed {
    logic signed [31:0] p1_nx;
    logic signed [31:0] p1_ny;
    logic signed [31:0] p1_nz;
    logic signed [31:0] p1_d;
    logic signed [31:0] p2_nx;
    logic signed [31:0] p2_ny;
    logic signed [31:0] p2_nz;
    logic signed [31:0] p2_d;
    logic signed [31:0] p3_nx;
    logic signed [31:0] p3_ny;
    logic signed [31:0] p3_nz;
    logic signed [31:0] p3_d;
  } planes_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               degenerate;
    logic               saturated;
  } point_t;

endpackage
`default_nettype wire

// ===== rtl/three_plane_intersection.sv =====
// Three-plane intersection point by Cramer's rule, fully pipelined.
`timescale 1ns / 1ps
`default_nettype none
// Takes three planes (normal and offset, signed fixed point with FRAC_BITS fraction bits) and
// returns their common point, truncated toward zero and saturated to 32 bits. One transaction
// enters per cycle while planes_ready is high; it passes 41 register stages: five stages of
// products, minors and sums, one stage of sign and degeneracy handling, an overflow check
// stage, then one quotient bit per stage over 33 division stages, then the output register.
// Each stage holds its item while the next one is full and cannot advance, so bubbles close
// up under output back-pressure. det_epsilon sits at address 0 and resets to 1.
module three_plane_intersection import tpi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              planes_valid,
  output      logic              planes_ready,
  input  wire planes_t           planes,
  output      logic              point_valid,
  input  wire logic              point_ready,
  output      point_t            point,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);

  localparam int PW = 64;
  localparam int MW = 65;
  localparam int TW = 97;
  localparam int WW = 99;
  localparam int NW = WW + FRAC_BITS;
  localparam int QB = 33;
  localparam int CW = ((NW > WW + QB) ? NW : (WW + QB)) + 1;
  localparam int DIV0 = 6;
  localparam int NS = DIV0 + QB + 2;

  logic [15:0] det_epsilon;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DET_EPSILON) ? {16'd0, det_epsilon} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon <= DET_EPSILON_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_DET_EPSILON) begin
      det_epsilon <= pwdata[15:0];
    end
  end

  logic [NS-1:0] v;
  logic [NS:0]   en;

  assign en[NS] = point_ready;
  genvar gi;
  generate
    for (gi = 0; gi < NS; gi++) begin : g_en
      assign en[gi] = !v[gi] || en[gi+1];
    end
  endgenerate

  assign planes_ready = en[0];
  assign point_valid  = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= planes_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // products that form the minors
  logic signed [PW-1:0] s0_pr [12];
  planes_t              s0_p;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_p      <= planes;
      s0_pr[0]  <= $signed(planes.p1_ny) * $signed(planes.p3_nz);
      s0_pr[1]  <= $signed(planes.p3_ny) * $signed(planes.p1_nz);
      s0_pr[2]  <= $signed(planes.p2_ny) * $signed(planes.p1_nz);
      s0_pr[3]  <= $signed(planes.p1_ny) * $signed(planes.p2_nz);
      s0_pr[4]  <= $signed(planes.p3_ny) * $signed(planes.p2_nz);
      s0_pr[5]  <= $signed(planes.p2_ny) * $signed(planes.p3_nz);
      s0_pr[6]  <= $signed(planes.p1_nx) * $signed(planes.p3_d);
      s0_pr[7]  <= $signed(planes.p3_nx) * $signed(planes.p1_d);
      s0_pr[8]  <= $signed(planes.p2_nx) * $signed(planes.p1_d);
      s0_pr[9]  <= $signed(planes.p1_nx) * $signed(planes.p2_d);
      s0_pr[10] <= $signed(planes.p3_nx) * $signed(planes.p2_d);
      s0_pr[11] <= $signed(planes.p2_nx) * $signed(planes.p3_d);
    end
  end

  // minors: bc1 bc2 bc3 ad1 ad2 ad3
  logic signed [MW-1:0] s1_mn [6];
  planes_t              s1_p;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_p <= s0_p;
      for (int j = 0; j < 6; j++) begin
        s1_mn[j] <= MW'(s0_pr[2*j]) - MW'(s0_pr[2*j+1]);
      end
    end
  end

  // split products of minors and coefficients
  logic signed [31:0]   t_c [12];
  logic signed [MW-1:0] t_m [12];

  always_comb begin
    t_c[0]  = s1_p.p1_d;  t_m[0]  = s1_mn[2];
    t_c[1]  = s1_p.p2_d;  t_m[1]  = s1_mn[0];
    t_c[2]  = s1_p.p3_d;  t_m[2]  = s1_mn[1];
    t_c[3]  = s1_p.p1_nz; t_m[3]  = s1_mn[5];
    t_c[4]  = s1_p.p2_nz; t_m[4]  = s1_mn[3];
    t_c[5]  = s1_p.p3_nz; t_m[5]  = s1_mn[4];
    t_c[6]  = s1_p.p1_ny; t_m[6]  = s1_mn[5];
    t_c[7]  = s1_p.p2_ny; t_m[7]  = s1_mn[3];
    t_c[8]  = s1_p.p3_ny; t_m[8]  = s1_mn[4];
    t_c[9]  = s1_p.p1_nx; t_m[9]  = s1_mn[2];
    t_c[10] = s1_p.p2_nx; t_m[10] = s1_mn[0];
    t_c[11] = s1_p.p3_nx; t_m[11] = s1_mn[1];
  end

  logic signed [MW-1:0] s2_hi [12];
  logic signed [MW-1:0] s2_lo [12];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int j = 0; j < 12; j++) begin
        s2_hi[j] <= $signed(t_m[j][MW-1:32]) * t_c[j];
        s2_lo[j] <= $signed({1'b0, t_m[j][31:0]}) * t_c[j];
      end
    end
  end

  logic signed [TW-1:0] s3_t [12];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int j = 0; j < 12; j++) begin
        s3_t[j] <= (TW'(s2_hi[j]) <<< 32) + TW'(s2_lo[j]);
      end
    end
  end

  // numerators x y z, then determinant
  logic signed [WW-1:0] s4_s [4];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_s[0] <= -WW'(s3_t[0]) - WW'(s3_t[1]) - WW'(s3_t[2]);
      s4_s[1] <= -WW'(s3_t[3]) - WW'(s3_t[4]) - WW'(s3_t[5]);
      s4_s[2] <= WW'(s3_t[6]) + WW'(s3_t[7]) + WW'(s3_t[8]);
      s4_s[3] <= -WW'(s3_t[9]) - WW'(s3_t[10]) - WW'(s3_t[11]);
    end
  end

  logic [WW-1:0] abs_w;
  logic [WW-1:0] abs_n [3];
  logic [WW-1:0] thr;

  always_comb begin
    abs_w = s4_s[3][WW-1] ? WW'(-s4_s[3]) : WW'(s4_s[3]);
    for (int k = 0; k < 3; k++) begin
      abs_n[k] = s4_s[k][WW-1] ? WW'(-s4_s[k]) : WW'(s4_s[k]);
    end
    thr = WW'({det_epsilon, {(2*FRAC_BITS){1'b0}}});
  end

  logic [NW-1:0] s5_n [3];
  logic [2:0]    s5_neg;
  logic [WW-1:0] s5_d;
  logic          s5_deg;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int k = 0; k < 3; k++) begin
        s5_n[k]   <= {abs_n[k], {FRAC_BITS{1'b0}}};
        s5_neg[k] <= s4_s[k][WW-1] ^ s4_s[3][WW-1];
      end
      s5_d   <= abs_w;
      s5_deg <= (abs_w == '0) || (abs_w < thr);
    end
  end

  // division: overflow check, then one quotient bit per stage
  logic [NW-1:0] dv_r   [QB+1][3];
  logic [QB-1:0] dv_q   [QB+1][3];
  logic [2:0]    dv_ovf [QB+1];
  logic [2:0]    dv_neg [QB+1];
  logic [WW-1:0] dv_d   [QB+1];
  logic          dv_deg [QB+1];

  always_ff @(posedge clk) begin
    if (en[DIV0]) begin
      for (int k = 0; k < 3; k++) begin
        dv_r[0][k]   <= s5_n[k];
        dv_q[0][k]   <= '0;
        dv_ovf[0][k] <= CW'(s5_n[k]) >= (CW'(s5_d) << QB);
      end
      dv_neg[0] <= s5_neg;
      dv_d[0]   <= s5_d;
      dv_deg[0] <= s5_deg;
    end
  end

  generate
    for (gi = 1; gi <= QB; gi++) begin : g_div
      logic [CW-1:0] sh;
      logic [2:0]    ge;
      assign sh = CW'(dv_d[gi-1]) << (QB - gi);
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          ge[k] = CW'(dv_r[gi-1][k]) >= sh;
        end
      end
      always_ff @(posedge clk) begin
        if (en[DIV0+gi]) begin
          for (int k = 0; k < 3; k++) begin
            dv_r[gi][k]   <= ge[k] ? NW'(CW'(dv_r[gi-1][k]) - sh) : dv_r[gi-1][k];
            dv_q[gi][k]   <= dv_q[gi-1][k] | (QB'(ge[k]) << (QB - gi));
            dv_ovf[gi][k] <= dv_ovf[gi-1][k];
          end
          dv_neg[gi] <= dv_neg[gi-1];
          dv_d[gi]   <= dv_d[gi-1];
          dv_deg[gi] <= dv_deg[gi-1];
        end
      end
    end
  endgenerate

  logic [31:0] crd [3];
  logic [2:0]  sat;
  point_t      res;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_neg[QB][k]) begin
        sat[k] = dv_ovf[QB][k] || (dv_q[QB][k] > QB'(32'h8000_0000));
        crd[k] = sat[k] ? 32'h8000_0000 : (32'd0 - dv_q[QB][k][31:0]);
      end else begin
        sat[k] = dv_ovf[QB][k] || dv_q[QB][k][32] || dv_q[QB][k][31];
        crd[k] = sat[k] ? 32'h7FFF_FFFF : dv_q[QB][k][31:0];
      end
    end
    if (dv_deg[QB]) begin
      res = '{point_x: '0, point_y: '0, point_z: '0, degenerate: 1'b1, saturated: 1'b0};
    end else begin
      res = '{point_x: crd[0], point_y: crd[1], point_z: crd[2], degenerate: 1'b0,
              saturated: |sat};
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      point <= res;
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb_three_plane_intersection.sv =====
// Testbench for the three-plane intersection block: directed table, random traffic, predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_three_plane_intersection;
  import tpi_pkg::*;

  localparam int N_RANDOM = 830;
  localparam int DRAIN_CYCLES = 60;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  typedef logic signed [159:0] wide_t;

  typedef struct {
    planes_t p;
    bit      has_exp;
    point_t  exp;
  } plane_row_t;

  logic              clk;
  logic              rst;
  logic              planes_valid;
  logic              planes_ready;
  planes_t           planes;
  logic              point_valid;
  logic              point_ready;
  point_t            point;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  point_t      pending_points[$];
  logic [15:0] eps_shadow;
  int          mismatches;
  int          hold_left;
  bit          timed_out;

  three_plane_intersection dut (
    .clk(clk), .rst(rst),
    .planes_valid(planes_valid), .planes_ready(planes_ready), .planes(planes),
    .point_valid(point_valid), .point_ready(point_ready), .point(point),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    timed_out = 1'b0;
    #(8 * 3_000_000);
    timed_out = 1'b1;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic wide_t wabs(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [31:0] to_coord(wide_t num, wide_t den, inout logic sat);
    logic  neg;
    wide_t q;
    neg = num[159] ^ den[159];
    q = (wabs(num) <<< 16) / wabs(den);
    if (neg) begin
      if (q > wide_t'(64'h8000_0000)) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return -q[31:0];
    end
    if (q > wide_t'(64'h7FFF_FFFF)) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  function automatic point_t predict_point(planes_t p, logic [15:0] eps);
    wide_t  n1x, n1y, n1z, d1, n2x, n2y, n2z, d2, n3x, n3y, n3z, d3;
    wide_t  bc1, bc2, bc3, ad1, ad2, ad3, nx, ny, nz, w, thr;
    point_t r;
    logic   sat;
    n1x = p.p1_nx; n1y = p.p1_ny; n1z = p.p1_nz; d1 = p.p1_d;
    n2x = p.p2_nx; n2y = p.p2_ny; n2z = p.p2_nz; d2 = p.p2_d;
    n3x = p.p3_nx; n3y = p.p3_ny; n3z = p.p3_nz; d3 = p.p3_d;
    bc1 = n1y * n3z - n3y * n1z;
    bc2 = n2y * n1z - n1y * n2z;
    bc3 = n3y * n2z - n2y * n3z;
    ad1 = n1x * d3 - n3x * d1;
    ad2 = n2x * d1 - n1x * d2;
    ad3 = n3x * d2 - n2x * d3;
    nx = -(d1 * bc3 + d2 * bc1 + d3 * bc2);
    ny = -(n1z * ad3 + n2z * ad1 + n3z * ad2);
    nz = n1y * ad3 + n2y * ad1 + n3y * ad2;
    w = -(n1x * bc3 + n2x * bc1 + n3x * bc2);
    thr = {144'd0, eps};
    thr = thr <<< 32;
    r = '0;
    if (w == 0 || wabs(w) < thr) begin
      r.degenerate = 1'b1;
      return r;
    end
    sat = 1'b0;
    r.point_x = to_coord(nx, w, sat);
    r.point_y = to_coord(ny, w, sat);
    r.point_z = to_coord(nz, w, sat);
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_word(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
      2: return $signed($urandom_range(0, 64)) - 32'sd32;
      default: return ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                      ^ $urandom_range(0, 3);
    endcase
  endfunction

  function automatic planes_t rand_planes();
    planes_t p;
    int      kind;
    int      sel;
    sel = $urandom_range(0, 9);
    kind = (sel < 4) ? 1 : (sel < 6) ? 0 : (sel < 8) ? 2 : 3;
    p = {rand_word(kind), rand_word(kind), rand_word(kind), rand_word(kind),
         rand_word(kind), rand_word(kind), rand_word(kind), rand_word(kind),
         rand_word(kind), rand_word(kind), rand_word(kind), rand_word(kind)};
    if (sel == 9) begin
      p.p3_nx = p.p1_nx + rand_word(2);
      p.p3_ny = p.p1_ny + rand_word(2);
      p.p3_nz = p.p1_nz + rand_word(2);
    end
    return p;
  endfunction

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== data[15:0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("readback det_epsilon: expected %h actual %h", data[15:0], prdata[15:0]);
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
    eps_shadow = data[15:0];
  endtask

  task automatic send_planes(planes_t p, bit has_exp, point_t exp);
    point_t pred;
    @(negedge clk);
    planes_valid = 1'b1;
    planes = p;
    do @(posedge clk); while (!planes_ready);
    pred = predict_point(p, eps_shadow);
    if (has_exp && pred !== exp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with predictor: %h vs %h", exp, pred);
    end
    pending_points.push_back(pred);
  endtask

  task automatic idle_sender(int n);
    @(negedge clk);
    planes_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_traffic(int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
      end
      burst--;
      send_planes(rand_planes(), 1'b0, '0);
    end
    idle_sender(0);
  endtask

  // receiver: stall pattern changes at random, with an optional long hold-off
  initial begin
    int mode;
    point_ready = 1'b0;
    hold_left = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        point_ready = 1'b0;
      end else begin
        case (mode)
          0: point_ready = 1'b1;
          1: point_ready = $urandom_range(0, 1);
          default: point_ready = ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    point_t exp;
    if (!rst && point_valid && point_ready) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %h", point);
      end else begin
        exp = pending_points.pop_front();
        if (point.point_x !== exp.point_x || point.point_y !== exp.point_y ||
            point.point_z !== exp.point_z || point.degenerate !== exp.degenerate ||
            point.saturated !== exp.saturated) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected x=%h y=%h z=%h deg=%b sat=%b,",
                     exp.point_x, exp.point_y, exp.point_z, exp.degenerate, exp.saturated);
            $display("          actual x=%h y=%h z=%h deg=%b sat=%b",
                     point.point_x, point.point_y, point.point_z, point.degenerate,
                     point.saturated);
          end
        end
      end
    end
  end

  initial begin
    plane_row_t rows[$];
    plane_row_t row;
    planes_t    p;
    point_t     exp;
    rst = 1'b1;
    planes_valid = 1'b0;
    planes = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mismatches = 0;
    eps_shadow = DET_EPSILON_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    exp = '0;
    exp.degenerate = 1'b1;
    row.p = '0; row.has_exp = 1'b1; row.exp = exp;
    rows.push_back(row);
    row.p = {12{32'h7FFF_FFFF}};
    rows.push_back(row);
    row.p = {12{32'h8000_0000}};
    rows.push_back(row);
    row.p = {ONE, 32'sd0, 32'sd0, -ONE, 32'sd0, ONE, 32'sd0, -2 * ONE,
             32'sd0, 32'sd0, ONE, -3 * ONE};
    row.exp = '{point_x: -ONE, point_y: -2 * ONE, point_z: -3 * ONE,
                degenerate: 1'b0, saturated: 1'b0};
    rows.push_back(row);
    row.has_exp = 1'b0;
    row.p = {32'sd1, 32'sd0, 32'sd0, 32'h8000_0000, 32'sd0, 32'sd1, 32'sd0, 32'h7FFF_FFFF,
             32'sd0, 32'sd0, 32'sd1, 32'sd0};
    rows.push_back(row);
    row.p = {32'h8000_0000, 32'sd0, 32'sd0, 32'h7FFF_FFFF, 32'sd0, 32'h7FFF_FFFF, 32'sd0,
             32'h8000_0000, 32'sd0, 32'sd0, 32'h8000_0000, 32'h8000_0000};
    rows.push_back(row);
    row.p = {ONE, ONE, 32'sd0, ONE, ONE, -ONE, 32'sd0, -ONE, 32'sd0, 32'sd0, ONE, 32'h7FFF_FFFF};
    rows.push_back(row);
    row.p = {ONE, 32'sd0, 32'sd0, 32'sd5, 32'sd0, ONE, 32'sd0, 32'sd5,
             32'sd1, 32'sd0, 32'sd1, 32'sd0};
    rows.push_back(row);
    row.p = {32'h7FFF_FFFF, 32'h8000_0000, 32'sd0, 32'sd0, 32'sd0, 32'h7FFF_FFFF, 32'h8000_0000,
             32'sd0, 32'h8000_0000, 32'sd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    rows.push_back(row);
    for (int i = 0; i < 6; i++) begin
      row.p = rand_planes();
      rows.push_back(row);
    end

    foreach (rows[i]) send_planes(rows[i].p, rows[i].has_exp, rows[i].exp);
    idle_sender(0);
    drain();

    apb_write({REG_DET_EPSILON, 2'b00}, 32'd0);
    foreach (rows[i]) send_planes(rows[i].p, 1'b0, '0);
    random_traffic(150);
    drain();

    apb_write({REG_DET_EPSILON, 2'b00}, 32'd65535);
    random_traffic(150);

    // hold off the receiver while the sender keeps offering
    hold_left = 400;
    for (int i = 0; i < 120; i++) send_planes(rand_planes(), 1'b0, '0);
    idle_sender(0);
    drain();

    apb_write({REG_DET_EPSILON, 2'b00}, $urandom_range(0, 65535));
    random_traffic(200);
    drain();

    apb_write({REG_DET_EPSILON, 2'b00}, 32'(DET_EPSILON_RST));
    random_traffic(N_RANDOM - 620);
    drain();

    if (mismatches == 0 && !timed_out) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
